/* src/srcd_pkg.sv */
`default_nettype none

package srcd_pkg;

    localparam int BYTE_W   = 8;
    localparam int WORD_W   = 16;
    localparam int WNUM_W   = 5;
    localparam int CONV_W   = 15;
    localparam int WPF_W    = 6;
    localparam int SCALE_W  = 15;
    localparam int PROD_W   = WORD_W + SCALE_W;

    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    // Hard ceiling on frame length set by the word index width
    localparam int HARD_WORDS = 32;

    localparam logic [1:0] REG_CRC_POLY   = 2'd0;
    localparam logic [1:0] REG_CRC_START  = 2'd1;
    localparam logic [1:0] REG_WORDS      = 2'd2;
    localparam logic [1:0] REG_MEAS_MODE  = 2'd3;

    localparam logic [BYTE_W-1:0] CRC_POLY_RST  = 8'h31;
    localparam logic [BYTE_W-1:0] CRC_START_RST = 8'hFF;
    localparam logic [WPF_W-1:0]  WORDS_RST     = 6'd2;
    localparam logic              MEAS_MODE_RST = 1'b1;

    // Full-scale factors: 175.00 degC span and 100.00 %RH span, in hundredths
    localparam logic [SCALE_W-1:0] TEMP_SCALE  = 15'd17500;
    localparam logic [SCALE_W-1:0] HUM_SCALE   = 15'd10000;
    localparam logic [WORD_W-1:0]  TEMP_OFFSET = 16'd4500;

    typedef enum logic [2:0] {
        PH_HIGH = 3'b001,
        PH_LOW  = 3'b010,
        PH_CRC  = 3'b100
    } phase_t;

    typedef struct packed {
        logic [WORD_W-1:0] data_word;
        logic              crc_ok;
        logic [WNUM_W-1:0] word_number;
        logic              last_word;
        logic              meas_mode;
    } cand_t;

    // MSB-first CRC-8 over one byte, top polynomial bit implicit
    function automatic logic [BYTE_W-1:0] crc8_step(
        input logic [BYTE_W-1:0] crc,
        input logic [BYTE_W-1:0] data,
        input logic [BYTE_W-1:0] poly
    );
        logic [BYTE_W-1:0] v;
        v = crc ^ data;
        for (int b = 0; b < BYTE_W; b++)
        begin
            v = v[BYTE_W-1] ? ((v << 1) ^ poly) : (v << 1);
        end
        return v;
    endfunction

endpackage

`default_nettype wire

/* src/srcd_ifs.sv */
`default_nettype none

interface srcd_byte_if;
    import srcd_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;
    logic              frame_start;

    modport source (output valid, output rx_byte, output frame_start, input ready);
    modport sink   (input valid, input rx_byte, input frame_start, output ready);
endinterface

interface srcd_word_if;
    import srcd_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [WORD_W-1:0]        data_word;
    logic                     crc_ok;
    logic                     frame_ok;
    logic [WNUM_W-1:0]        word_number;
    logic                     last_word;
    logic signed [CONV_W-1:0] converted_value;

    modport source (output valid, output data_word, output crc_ok, output frame_ok,
                    output word_number, output last_word, output converted_value,
                    input ready);
    modport sink   (input valid, input data_word, input crc_ok, input frame_ok,
                    input word_number, input last_word, input converted_value,
                    output ready);
endinterface

`default_nettype wire

/* src/srcd_crc_track.sv */
`default_nettype none

module srcd_crc_track #(
    parameter int MAX_WORDS = 32
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    srcd_byte_if.sink                        rx,
    input  wire logic [srcd_pkg::BYTE_W-1:0] crc_poly,
    input  wire logic [srcd_pkg::BYTE_W-1:0] crc_start,
    input  wire logic [srcd_pkg::WPF_W-1:0]  words_per_frame,
    input  wire logic                        meas_mode,
    output      logic                        cand_valid,
    output      srcd_pkg::cand_t             cand,
    input  wire logic                        cand_ready
);
    import srcd_pkg::*;

    localparam int CAP = (MAX_WORDS < HARD_WORDS) ? MAX_WORDS : HARD_WORDS;
    localparam logic [WPF_W-1:0] CAP_W = WPF_W'(CAP);

    phase_t            phase_reg, phase_next, phase_eff;
    logic [BYTE_W-1:0] crc_reg, crc_next;
    logic [BYTE_W-1:0] high_reg, high_next;
    logic [BYTE_W-1:0] low_reg, low_next;
    logic [WNUM_W-1:0] cnt_reg, cnt_next, cnt_eff;
    logic              failed_reg, failed_next, failed_eff;
    logic              cand_valid_reg, cand_valid_next;
    cand_t             cand_reg, cand_next;

    logic              in_fire;
    logic              cand_load;
    logic              crc_match;
    logic              is_last;
    logic [WPF_W-1:0]  wpf_eff;
    logic [WNUM_W-1:0] last_index;

    assign rx.ready   = !cand_valid_reg || cand_ready;
    assign in_fire    = rx.valid && rx.ready;
    assign cand_valid = cand_valid_reg;
    assign cand       = cand_reg;

    always_comb
    begin
        wpf_eff = (words_per_frame == '0) ? WPF_W'(1) : words_per_frame;
        if (wpf_eff > CAP_W)
        begin
            wpf_eff = CAP_W;
        end
        last_index = WNUM_W'(wpf_eff - WPF_W'(1));
    end

    always_comb
    begin
        // frame start restarts position and error before the byte is used
        phase_eff  = rx.frame_start ? PH_HIGH : phase_reg;
        cnt_eff    = rx.frame_start ? '0 : cnt_reg;
        failed_eff = rx.frame_start ? 1'b0 : failed_reg;

        crc_match = (rx.rx_byte == crc_reg);
        is_last   = (cnt_eff == last_index);

        phase_next  = phase_reg;
        crc_next    = crc_reg;
        high_next   = high_reg;
        low_next    = low_reg;
        cnt_next    = cnt_reg;
        failed_next = failed_reg;
        cand_load   = 1'b0;
        cand_next   = cand_reg;

        if (in_fire)
        begin
            case (phase_eff)
                PH_HIGH:
                begin
                    high_next   = rx.rx_byte;
                    crc_next    = crc8_step(crc_start, rx.rx_byte, crc_poly);
                    cnt_next    = cnt_eff;
                    failed_next = failed_eff;
                    phase_next  = PH_LOW;
                end
                PH_LOW:
                begin
                    low_next   = rx.rx_byte;
                    crc_next   = crc8_step(crc_reg, rx.rx_byte, crc_poly);
                    phase_next = PH_CRC;
                end
                PH_CRC:
                begin
                    cand_load             = !failed_eff;
                    cand_next.data_word   = {high_reg, low_reg};
                    cand_next.crc_ok      = crc_match;
                    cand_next.word_number = cnt_eff;
                    cand_next.last_word   = is_last;
                    cand_next.meas_mode   = meas_mode;
                    crc_next              = crc_start;
                    phase_next            = PH_HIGH;
                    if (is_last)
                    begin
                        cnt_next    = '0;
                        failed_next = 1'b0;
                    end
                    else
                    begin
                        cnt_next    = cnt_eff + WNUM_W'(1);
                        failed_next = failed_eff || !crc_match;
                    end
                end
                default:
                begin
                    phase_next = PH_HIGH;
                end
            endcase
        end

        if (cand_load)
        begin
            cand_valid_next = 1'b1;
        end
        else if (cand_ready)
        begin
            cand_valid_next = 1'b0;
        end
        else
        begin
            cand_valid_next = cand_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_HIGH;
            crc_reg        <= CRC_START_RST;
            cnt_reg        <= '0;
            failed_reg     <= 1'b0;
            cand_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            crc_reg        <= crc_next;
            cnt_reg        <= cnt_next;
            failed_reg     <= failed_next;
            cand_valid_reg <= cand_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        high_reg <= high_next;
        low_reg  <= low_next;
        if (cand_load)
        begin
            cand_reg <= cand_next;
        end
    end

    a_cand_from_crc_byte: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(cand_valid_reg) |-> $past(in_fire && phase_eff == PH_CRC))
        else $error("candidate word appeared without a CRC byte transfer");

    a_phase_wraps: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && phase_eff == PH_CRC) |=> (phase_reg == PH_HIGH))
        else $error("byte phase did not return to high byte after CRC byte");

    a_frame_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && phase_eff == PH_CRC && is_last) |=> (cnt_reg == '0 && !failed_reg))
        else $error("word count or failure flag not cleared at frame end");

endmodule

`default_nettype wire

/* src/srcd_convert.sv */
`default_nettype none

module srcd_convert (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            cand_valid,
    input  wire srcd_pkg::cand_t cand,
    output      logic            cand_ready,
    srcd_word_if.source          res
);
    import srcd_pkg::*;

    logic                     out_valid_reg;
    logic [WORD_W-1:0]        word_reg;
    logic                     ok_reg;
    logic [WNUM_W-1:0]        wnum_reg;
    logic                     last_reg;
    logic signed [CONV_W-1:0] conv_reg, conv_next;

    logic                     load;
    logic [SCALE_W-1:0]       scale;
    logic [PROD_W-1:0]        prod;
    logic [PROD_W:0]          quo_sum;
    logic [WORD_W-1:0]        quo;

    assign cand_ready = !out_valid_reg || res.ready;
    assign load       = cand_valid && cand_ready;

    assign scale = (cand.word_number == '0) ? TEMP_SCALE : HUM_SCALE;
    assign prod  = PROD_W'(cand.data_word) * PROD_W'(scale);

    // floor(p / 65535) = (p + (p >> 16) + 1) >> 16 while the quotient stays below 2^16
    assign quo_sum = (PROD_W+1)'(prod) + (PROD_W+1)'(prod >> WORD_W) + (PROD_W+1)'(1);
    assign quo     = quo_sum[WORD_W +: WORD_W];

    always_comb
    begin
        conv_next = '0;
        if (cand.meas_mode)
        begin
            if (cand.word_number == '0)
            begin
                conv_next = CONV_W'(quo - TEMP_OFFSET);
            end
            else if (cand.word_number == WNUM_W'(1))
            begin
                conv_next = CONV_W'(quo);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            word_reg <= cand.data_word;
            ok_reg   <= cand.crc_ok;
            wnum_reg <= cand.word_number;
            last_reg <= cand.last_word;
            conv_reg <= conv_next;
        end
    end

    assign res.valid           = out_valid_reg;
    assign res.data_word       = word_reg;
    assign res.crc_ok          = ok_reg;
    assign res.frame_ok        = ok_reg;
    assign res.word_number     = wnum_reg;
    assign res.last_word       = last_reg;
    assign res.converted_value = conv_reg;

endmodule

`default_nettype wire

/* src/sensor_response_crc_deframer_unit.sv */
// Sensor response CRC deframer.
// rx carries one received response byte per transfer, with frame_start
// marking the first byte of a new response. Every three bytes form one
// word: high data byte, low data byte, then a CRC-8 over the two.
// res carries one result per CRC byte: the word, its CRC check, the
// frame status, the word index, a last-word mark and, in measurement
// mode, the temperature (word 0) or humidity (word 1) in hundredths.
// After a word fails its CRC, the rest of that frame gives no result.
// Configuration goes through the APB port, four 32-bit registers at
// byte offsets 0, 4, 8 and 12; pready is tied high.
// Throughput: one byte per cycle, sustained while res accepts results. A
// result goes from its CRC byte transfer into the word candidate
// register, then through the scale multiplier and constant divide
// into the output register.
// Reset clears the byte position, word count and failure flag, and
// loads the register defaults. When res stalls, the output and the
// candidate register hold; rx stalls for any byte while the candidate
// register holds a word that the output register cannot take yet.
`default_nettype none

module sensor_response_crc_deframer_unit #(
    parameter int MAX_WORDS = 32
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    srcd_byte_if.sink                            rx,
    srcd_word_if.source                          res,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [srcd_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [srcd_pkg::APB_DATA_W-1:0] pwdata,
    output      logic [srcd_pkg::APB_DATA_W-1:0] prdata,
    output      logic                            pready
);
    import srcd_pkg::*;

    logic [BYTE_W-1:0] crc_poly_reg;
    logic [BYTE_W-1:0] crc_start_reg;
    logic [WPF_W-1:0]  words_reg;
    logic              meas_mode_reg;

    logic              cfg_write;
    logic [1:0]        reg_sel;

    logic              cand_valid;
    logic              cand_ready;
    cand_t             cand;

    assign pready    = 1'b1;
    assign reg_sel   = paddr[3:2];
    // write lands on the access phase
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_poly_reg  <= CRC_POLY_RST;
            crc_start_reg <= CRC_START_RST;
            words_reg     <= WORDS_RST;
            meas_mode_reg <= MEAS_MODE_RST;
        end
        else if (cfg_write)
        begin
            case (reg_sel)
                REG_CRC_POLY:  crc_poly_reg  <= pwdata[BYTE_W-1:0];
                REG_CRC_START: crc_start_reg <= pwdata[BYTE_W-1:0];
                REG_WORDS:     words_reg     <= pwdata[WPF_W-1:0];
                REG_MEAS_MODE: meas_mode_reg <= pwdata[0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_CRC_POLY:  prdata = APB_DATA_W'(crc_poly_reg);
            REG_CRC_START: prdata = APB_DATA_W'(crc_start_reg);
            REG_WORDS:     prdata = APB_DATA_W'(words_reg);
            REG_MEAS_MODE: prdata = APB_DATA_W'(meas_mode_reg);
            default:       prdata = '0;
        endcase
    end

    // byte position, running CRC and frame bookkeeping
    srcd_crc_track #(
        .MAX_WORDS (MAX_WORDS)
    ) u_crc_track (
        .clk             (clk),
        .rst_n           (rst_n),
        .rx              (rx),
        .crc_poly        (crc_poly_reg),
        .crc_start       (crc_start_reg),
        .words_per_frame (words_reg),
        .meas_mode       (meas_mode_reg),
        .cand_valid      (cand_valid),
        .cand            (cand),
        .cand_ready      (cand_ready)
    );

    // scale conversion and output register
    srcd_convert u_convert (
        .clk        (clk),
        .rst_n      (rst_n),
        .cand_valid (cand_valid),
        .cand       (cand),
        .cand_ready (cand_ready),
        .res        (res)
    );

endmodule

`default_nettype wire
